FILE: rtl/two_level_page_table_mapper_macros.svh
// assertion macros for the page table mapper
// assertions made with the shorthand are clocked on i_clk and held off while i_rst_n is low
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH

// generic clocked assertion with explicit clock and reset
`define TLPTM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// shorthand using the block clock and reset
`define TLPTM_ASSERT(label, prop, msg) \
    `TLPTM_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/tlptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptm_pkg
// types and constants shared by the page table mapper
// ----------------------------------------------------------------------------
package tlptm_pkg;

    localparam int IDX_W             = 10;
    localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
    localparam int FRAME_W           = 20;
    localparam int ATTR_W            = 12;
    localparam int WORD_W            = 32;
    localparam int COUNT_W           = 10;
    localparam int STATUS_W          = 3;
    localparam int CFG_IDX_W         = 1;

    // request kinds
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_UNMAP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW_TABLE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTORY_FRAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE_FRAME = 1'b1;

    localparam logic [FRAME_W-1:0] DIRECTORY_FRAME_RST  = 20'd39;
    localparam logic [FRAME_W-1:0] STORE_BASE_FRAME_RST = 20'd39;
    localparam logic [FRAME_W-1:0] FIRST_FREE_FRAME     = 20'h00100;
    localparam logic [ATTR_W-1:0]  NEW_DIR_FLAGS        = 12'h007;

    // directory entry flag bits
    localparam int PDE_PRESENT = 0;
    localparam int PDE_RW      = 1;
    localparam int PDE_US      = 2;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] virtual_page;
        logic [FRAME_W-1:0] physical_frame;
        logic [ATTR_W-1:0]  page_attributes;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  frames_left;
    } t_out_word;

endpackage

FILE: rtl/two_level_page_table_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_mapper
// maps and unmaps 4 KiB pages in two-level page tables kept in an on-chip store
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_word) carries one request
//   word: map or unmap of one virtual page. output channel (o_out_valid /
//   i_out_ready / o_out_word) returns one status word per request.
//   config port (i_cfg_we / i_cfg_idx / i_cfg_data) sets the directory frame
//   and the store base frame; write it only while no request is in flight.
// throughput
//   one request at a time over the single-port table store.
//   a status decided from the directory read alone, or a directory outside
//   the store, skips the table entry write. a map that allocates a new table
//   first clears its 1024 words through the store's one write port.
// reset
//   after reset the whole store is swept to zero, one word per cycle
//   (STORE_PAGES * 1024 words, 262144 at the default); o_in_ready stays low
//   until the sweep ends. config writes are taken during the sweep.
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and a finished result waits in its final state until the slot frees
// ----------------------------------------------------------------------------
`include "two_level_page_table_mapper_macros.svh"

module two_level_page_table_mapper
    import tlptm_pkg::*;
#(
    parameter int STORE_PAGES = 256,
    parameter int FREE_FRAMES = 768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FRAME_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = $clog2(STORE_PAGES);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = STORE_PAGES * ENTRIES_PER_TABLE;
    localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(DEPTH - 1);
    localparam logic [FRAME_W-1:0] PAGES_LIMIT = FRAME_W'(STORE_PAGES);
    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(ENTRIES_PER_TABLE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DADDR,
        S_PDE,
        S_ZERO,
        S_NEWDIR,
        S_PTE,
        S_FIN
    } t_state;

    // table store: one word port, registered read data
    logic [WORD_W-1:0] mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    // control and payload registers
    t_state               r_state,      n_state;
    logic [ADDR_W-1:0]    r_clr_addr,   n_clr_addr;
    t_in_word             r_req,        n_req;
    logic [SLOT_W-1:0]    r_dslot,      n_dslot;
    logic [SLOT_W-1:0]    r_tslot,      n_tslot;
    logic [IDX_W-1:0]     r_zidx,       n_zidx;
    logic [STATUS_W-1:0]  r_status,     n_status;
    logic [FRAME_W-1:0]   r_next_free,  n_next_free;
    logic [COUNT_W-1:0]   r_free_count, n_free_count;
    logic [FRAME_W-1:0]   r_dir_frame,  n_dir_frame;
    logic [FRAME_W-1:0]   r_base_frame, n_base_frame;
    logic                 r_out_valid,  n_out_valid;
    t_out_word            r_out_word,   n_out_word;

    // frame offsets within the store
    logic [FRAME_W-1:0] dir_off, pde_off, nf_off;
    logic               dir_in, pde_in, nf_in;
    logic [WORD_W-1:0]  pde_upd;
    logic [ADDR_W-1:0]  dir_addr, pte_addr;

    assign dir_off = r_dir_frame - r_base_frame;
    assign pde_off = r_rdata[WORD_W-1 -: FRAME_W] - r_base_frame;
    assign nf_off  = r_next_free - r_base_frame;
    assign dir_in  = dir_off < PAGES_LIMIT;
    assign pde_in  = pde_off < PAGES_LIMIT;
    assign nf_in   = nf_off < PAGES_LIMIT;

    assign dir_addr = {r_dslot, r_req.virtual_page[FRAME_W-1 -: IDX_W]};
    assign pte_addr = {r_tslot, r_req.virtual_page[IDX_W-1:0]};

    // directory entry flag update for a present table
    always_comb begin
        pde_upd = r_rdata;
        if (r_req.page_attributes[PDE_RW]) begin
            pde_upd[PDE_RW] = 1'b1;
        end
        if (!r_req.page_attributes[PDE_US]) begin
            pde_upd[PDE_US] = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_req        = r_req;
        n_dslot      = r_dslot;
        n_tslot      = r_tslot;
        n_zidx       = r_zidx;
        n_status     = r_status;
        n_next_free  = r_next_free;
        n_free_count = r_free_count;
        n_dir_frame  = r_dir_frame;
        n_base_frame = r_base_frame;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        mem_we       = 1'b0;
        mem_addr     = pte_addr;
        mem_wdata    = '0;

        // output slot drains when the receiver takes the word
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTORY_FRAME:  n_dir_frame  = i_cfg_data;
                CFG_STORE_BASE_FRAME: n_base_frame = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            // zero sweep of the whole store after reset
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_word;
                    n_state = S_DADDR;
                end
            end
            // read the directory entry
            S_DADDR: begin
                if (!dir_in) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_FIN;
                end else begin
                    mem_addr = {dir_off[SLOT_W-1:0], r_req.virtual_page[FRAME_W-1 -: IDX_W]};
                    n_dslot  = dir_off[SLOT_W-1:0];
                    n_state  = S_PDE;
                end
            end
            // directory entry is in r_rdata
            S_PDE: begin
                if (r_req.kind == KIND_UNMAP) begin
                    if (!r_rdata[PDE_PRESENT]) begin
                        n_status = ST_NOT_PRESENT;
                        n_state  = S_FIN;
                    end else if (!pde_in) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_FIN;
                    end else begin
                        n_tslot  = pde_off[SLOT_W-1:0];
                        n_status = ST_DONE;
                        n_state  = S_PTE;
                    end
                end else if (r_rdata[PDE_PRESENT]) begin
                    if (!pde_in) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_FIN;
                    end else begin
                        mem_we    = 1'b1;
                        mem_addr  = dir_addr;
                        mem_wdata = pde_upd;
                        n_tslot   = pde_off[SLOT_W-1:0];
                        n_status  = ST_DONE;
                        n_state   = S_PTE;
                    end
                end else if (r_free_count == '0) begin
                    n_status = ST_NO_FRAME;
                    n_state  = S_FIN;
                end else if (!nf_in) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_FIN;
                end else begin
                    n_tslot = nf_off[SLOT_W-1:0];
                    n_zidx  = '0;
                    n_state = S_ZERO;
                end
            end
            // clear the freshly taken table
            S_ZERO: begin
                mem_we   = 1'b1;
                mem_addr = {r_tslot, r_zidx};
                n_zidx   = r_zidx + 1'b1;
                if (r_zidx == LAST_IDX) begin
                    n_state = S_NEWDIR;
                end
            end
            // enter the new table in the directory and consume the frame
            S_NEWDIR: begin
                mem_we       = 1'b1;
                mem_addr     = dir_addr;
                mem_wdata    = {r_next_free, NEW_DIR_FLAGS};
                n_next_free  = r_next_free + 1'b1;
                n_free_count = r_free_count - 1'b1;
                n_status     = ST_NEW_TABLE;
                n_state      = S_PTE;
            end
            // write or zero the table entry
            S_PTE: begin
                mem_we   = 1'b1;
                mem_addr = pte_addr;
                if (r_req.kind == KIND_UNMAP) begin
                    mem_wdata = '0;
                end else begin
                    mem_wdata = {r_req.physical_frame, r_req.page_attributes};
                end
                n_state = S_FIN;
            end
            // hand the result to the output slot once it is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = r_status;
                    n_out_word.frames_left = r_free_count;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_next_free  <= FIRST_FREE_FRAME;
            r_free_count <= COUNT_W'(FREE_FRAMES);
            r_dir_frame  <= DIRECTORY_FRAME_RST;
            r_base_frame <= STORE_BASE_FRAME_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_next_free  <= n_next_free;
            r_free_count <= n_free_count;
            r_dir_frame  <= n_dir_frame;
            r_base_frame <= n_base_frame;
            r_out_valid  <= n_out_valid;
        end
        r_req      <= n_req;
        r_dslot    <= n_dslot;
        r_tslot    <= n_tslot;
        r_zidx     <= n_zidx;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    // an accepted request always starts with the directory lookup
    `TLPTM_ASSERT(a_accept_to_lookup, (i_in_valid && o_in_ready) |=> (r_state == S_DADDR), "accepted request did not start lookup")

    // the free frame count moves only when a new table is entered
    `TLPTM_ASSERT(a_count_on_newdir, ($past(i_rst_n) && (r_free_count != $past(r_free_count))) |-> ($past(r_state) == S_NEWDIR), "free count changed outside table allocation")

    // a new result appears only from the final state
    `TLPTM_ASSERT(a_out_from_fin, ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_FIN), "result appeared outside final state")

    // the store sweep never overlaps request intake
    `TLPTM_ASSERT(a_no_intake_in_clear, (r_state == S_CLEAR) |-> !o_in_ready, "request intake during store sweep")

endmodule
